// File: rtl/spq_pkg.sv
package spq_pkg;

  // Field widths of the request and response transfers
  localparam int KEY_W         = 16;
  localparam int PAYLOAD_W     = 32;
  localparam int ENTRY_COUNT_W = 5;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_FULL_PUSH = 2'd1,
    ERR_EMPTY_POP = 2'd2
  } error_t;

  typedef struct packed {
    action_t               action;
    logic [KEY_W-1:0]      key;
    logic [PAYLOAD_W-1:0]  payload;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]         top_key;
    logic [PAYLOAD_W-1:0]     top_payload;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     is_empty;
    logic                     is_full;
    error_t                   error_code;
  } rsp_t;

  // One stored entry
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // Broadcast from the control to every cell
  typedef struct packed {
    logic   push;
    logic   pop;
    logic   smallest_first;
    entry_t fresh;
  } cell_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       prev_before,
  input  entry_t     up_entry,
  input  entry_t     down_entry,
  output logic       before_new,
  output entry_t     entry,
  output entry_t     entry_next
);

  // Stored entry is served ahead of the incoming one (ties stay ahead: FIFO)
  always_comb begin
    if (ctrl.smallest_first) begin
      before_new = occupied && (entry.key <= ctrl.fresh.key);
    end else begin
      before_new = occupied && (entry.key >= ctrl.fresh.key);
    end
  end

  // Keep, insert, shift down on push; shift up on pop
  always_comb begin
    entry_next = entry;
    if (ctrl.push) begin
      if (before_new) begin
        entry_next = entry;
      end else if (prev_before) begin
        entry_next = ctrl.fresh;
      end else begin
        entry_next = up_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = down_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue built as a row of entry cells, head cell first.
// Request channel (req_valid / req_stall / req): each transfer is a push of
// req.key and req.payload, or a pop of the head entry. Response channel
// (rsp_valid / rsp_stall / rsp): exactly one response per request, giving
// the head entry, the count, the empty and full flags and an error code as
// they stand after that request.
// The response is registered and valid in the cycle after the request transfer.
// Throughput: one request per cycle while req_stall is low; every cell compares
// its key with the broadcast key and loads from itself, its neighbor or the new
// entry in the same cycle, so the whole row updates together.
// The response register holds one result; while rsp_stall holds it, req_stall
// is raised and no further request is taken until the result is taken.
// Pushes on a full queue are dropped and flagged, pops on an empty queue flagged.
// Configuration: cfg_we with cfg_wdata[0] sets serve_smallest_first (0 serves
// the largest key first); a write that changes the order empties the queue.
// Reset (rst, synchronous): the queue is empty, no response pending and the
// order is largest first. No clearing pass is needed.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             serve_smallest_first;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] op_count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             push_do;
  logic             pop_do;
  logic             cfg_clear;
  error_t           err;
  cell_ctrl_t       ctrl;
  rsp_t             rsp_next;

  entry_t           cell_entry [DEPTH];
  entry_t           cell_next  [DEPTH];
  entry_t           up_entry   [DEPTH];
  entry_t           down_entry [DEPTH];
  logic [DEPTH-1:0] ahead;
  logic [DEPTH-1:0] prev_before;
  logic [DEPTH-1:0] occupied;

  // Handshake: the response register frees up when its transfer happens
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full      = (count == CNT_W'(DEPTH));
  assign push_do   = accept && (req.action == ACT_PUSH) && !full;
  assign pop_do    = accept && (req.action == ACT_POP) && (count != '0);
  assign cfg_clear = cfg_we && (cfg_wdata != serve_smallest_first);

  always_comb begin
    err = ERR_OK;
    if (req.action == ACT_PUSH && full) begin
      err = ERR_FULL_PUSH;
    end else if (req.action == ACT_POP && count == '0) begin
      err = ERR_EMPTY_POP;
    end
  end

  // Count after the operation, then the order change clear
  always_comb begin
    op_count = count;
    if (push_do) begin
      op_count = count + 1'b1;
    end else if (pop_do) begin
      op_count = count - 1'b1;
    end
    count_next = cfg_clear ? '0 : op_count;
  end

  assign ctrl.push           = push_do;
  assign ctrl.pop            = pop_do;
  assign ctrl.smallest_first = serve_smallest_first;
  assign ctrl.fresh.key      = req.key;
  assign ctrl.fresh.payload  = req.payload;

  // Cell row with neighbor links
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occupied[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_head
      assign up_entry[i]    = ctrl.fresh;
      assign prev_before[i] = 1'b1;
    end else begin : g_mid
      assign up_entry[i]    = cell_entry[i-1];
      assign prev_before[i] = ahead[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign down_entry[i] = '0;
    end else begin : g_link
      assign down_entry[i] = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied[i]),
      .prev_before (prev_before[i]),
      .up_entry    (up_entry[i]),
      .down_entry  (down_entry[i]),
      .before_new  (ahead[i]),
      .entry       (cell_entry[i]),
      .entry_next  (cell_next[i])
    );
  end

  // Response built from the head cell's next value
  always_comb begin
    rsp_next.top_key     = (op_count != '0) ? cell_next[0].key : '0;
    rsp_next.top_payload = (op_count != '0) ? cell_next[0].payload : '0;
    rsp_next.entry_count = ENTRY_COUNT_W'(op_count);
    rsp_next.is_empty    = (op_count == '0);
    rsp_next.is_full     = (op_count == CNT_W'(DEPTH));
    rsp_next.error_code  = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count                <= '0;
      serve_smallest_first <= 1'b0;
      rsp_valid            <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_we) begin
        serve_smallest_first <= cfg_wdata;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push_do && !cfg_we |=> count == $past(count) + 1'b1)
    else $error("accepted push did not add one entry");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == ACT_PUSH && full && !cfg_we |=> count == $past(count)
      && rsp.error_code == ERR_FULL_PUSH)
    else $error("push on full queue changed the queue");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |-> rsp.top_key == '0 && rsp.top_payload == '0)
    else $error("empty response carries an entry");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import spq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 340;

  // Order model of the queue plus the list of responses still owed
  class spq_scoreboard;
    logic [KEY_W-1:0]     keys [DEPTH_DEFAULT];
    logic [PAYLOAD_W-1:0] payloads [DEPTH_DEFAULT];
    int unsigned          held;
    bit                   smallest_first;
    rsp_t                 owed_q[$];
    int                   errors;
    int                   checked;
    int                   n_push, n_pop, n_full_drop, n_empty_pop, n_max_held;

    function new();
      held = 0;
      smallest_first = 1'b0;
    endfunction

    // Changing the serving order flushes the table
    function void note_order(bit v);
      if (v != smallest_first) held = 0;
      smallest_first = v;
    endfunction

    // Apply one accepted request and queue the response it should produce
    function void note_request(req_t r);
      rsp_t        e;
      error_t      err;
      int unsigned slot;
      err = ERR_OK;
      if (r.action == ACT_PUSH) begin
        n_push++;
        if (held >= DEPTH_DEFAULT) begin
          err = ERR_FULL_PUSH;
          n_full_drop++;
        end else begin
          // table runs from last served (index 0) to next served (held-1);
          // a new key goes below every entry it does not beat, so ties stay FIFO
          slot = 0;
          while (slot < held && (smallest_first ? keys[slot] > r.key : keys[slot] < r.key))
            slot++;
          for (int i = held; i > slot; i--) begin
            keys[i]     = keys[i-1];
            payloads[i] = payloads[i-1];
          end
          keys[slot]     = r.key;
          payloads[slot] = r.payload;
          held++;
        end
      end else begin
        n_pop++;
        if (held == 0) begin
          err = ERR_EMPTY_POP;
          n_empty_pop++;
        end else begin
          held--;
        end
      end
      if (held > n_max_held) n_max_held = held;
      e.top_key     = (held != 0) ? keys[held-1] : '0;
      e.top_payload = (held != 0) ? payloads[held-1] : '0;
      e.entry_count = ENTRY_COUNT_W'(held);
      e.is_empty    = (held == 0);
      e.is_full     = (held >= DEPTH_DEFAULT);
      e.error_code  = err;
      owed_q.push_back(e);
    endfunction

    function void mismatch(string field, longint unsigned exp, logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp, got);
    endfunction

    // Compare one accepted response with the oldest owed one
    function void check_response(rsp_t got);
      rsp_t e;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response %h, expected none", $time, got);
        return;
      end
      e = owed_q.pop_front();
      checked++;
      if (got.top_key !== e.top_key)         mismatch("top_key", e.top_key, got.top_key);
      if (got.top_payload !== e.top_payload) mismatch("top_payload", e.top_payload,
                                                      got.top_payload);
      if (got.entry_count !== e.entry_count) mismatch("entry_count", e.entry_count,
                                                      got.entry_count);
      if (got.is_empty !== e.is_empty)       mismatch("is_empty", e.is_empty, got.is_empty);
      if (got.is_full !== e.is_full)         mismatch("is_full", e.is_full, got.is_full);
      if (got.error_code !== e.error_code)   mismatch("error_code", e.error_code,
                                                      got.error_code);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_we;
  logic cfg_wdata;

  spq_scoreboard sb;
  int            send_idle_pct;
  int            stall_pct;
  int            quiet_cycles;

  sorted_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    sb = new();
  end

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(negedge clk) begin
    rsp_stall = ($urandom_range(99) < stall_pct);
  end

  // Observe every transfer and register write at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.note_order(cfg_wdata);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      if (req_valid && !req_stall) sb.note_request(req);
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one request; returns at the falling edge after its transfer
  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req       = r;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic push(logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p);
    req_t r;
    r.action  = ACT_PUSH;
    r.key     = k;
    r.payload = p;
    send_request(r);
  endtask

  task automatic pop();
    req_t r;
    r.action  = ACT_POP;
    r.key     = KEY_W'($urandom);
    r.payload = $urandom;
    send_request(r);
  endtask

  // Let every owed response arrive, then idle on spare cycles
  task automatic drain();
    req_valid = 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Order register write, only with the queue idle
  task automatic write_order(bit v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic req_t random_request(int push_pct);
    req_t r;
    int   pick;
    r.action  = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
    r.payload = $urandom;
    pick = $urandom_range(9);
    // narrow key ranges force plenty of ties
    if (pick < 4)       r.key = KEY_W'($urandom_range(7));
    else if (pick == 4) r.key = '0;
    else if (pick == 5) r.key = '1;
    else if (pick == 6) r.key = KEY_W'($urandom_range(16'hffff, 16'hfff8));
    else                r.key = KEY_W'($urandom);
    return r;
  endfunction

  initial begin
    int idle_set [4];
    int stall_set [4];
    int push_pct;
    int pct_set [3];
    idle_set  = '{0, 86, 0, 34};
    stall_set = '{0, 0, 86, 34};
    pct_set   = '{15, 50, 85};
    push_pct  = 50;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: pop on empty, fill with extremes and ties, push on full
    pop();
    push(16'h0000, 32'h0000_0000);
    push(16'hffff, 32'hffff_ffff);
    push(16'h8000, 32'haaaa_0001);
    push(16'h8000, 32'haaaa_0002);
    push(16'h8000, 32'haaaa_0003);
    push(16'h7fff, 32'h5555_5555);
    push(16'h0001, 32'h0000_0001);
    push(16'hffff, 32'h0000_0002);
    push(16'h0000, 32'h8000_0000);
    for (int i = 0; i < 7; i++) push(KEY_W'($urandom), $urandom);
    push(16'h1234, 32'hdead_beef);
    pop();
    pop();
    pop();
    // switching to smallest first while loaded flushes the queue
    write_order(1'b1);
    push(16'h0005, 32'h0000_0a0a);
    push(16'h0005, 32'h0000_0b0b);
    // rewriting the same order keeps the contents
    write_order(1'b1);
    pop();
    pop();
    pop();

    // Random phases with different idle / stall mixes and both orders
    for (int ph = 0; ph < 4; ph++) begin
      write_order(ph[0]);
      send_idle_pct = idle_set[ph];
      stall_pct     = stall_set[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) push_pct = pct_set[$urandom_range(2)];
        send_request(random_request(push_pct));
      end
    end

    drain();
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (4) @(negedge clk);

    $display("Covered %0d pushes (%0d dropped on full) and %0d pops (%0d on empty)",
             sb.n_push, sb.n_full_drop, sb.n_pop, sb.n_empty_pop);
    $display("Checked %0d responses in both serving orders, peak occupancy %0d",
             sb.checked, sb.n_max_held);
    if (sb.owed_q.size() != 0)
      $display("%0t: %0d responses never arrived", $time, sb.owed_q.size());
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
verif/tb_top.sv
